### rtl/att_pkg.sv
// Package for the ANSI text terminal: shared types, codes and constants.
// Depends on nothing; the interface file and all modules but att_ram use it.
package att_pkg;

  localparam logic [1:0] FUNC_PUT    = 2'd0;
  localparam logic [1:0] FUNC_CURSOR = 2'd1;
  localparam logic [1:0] FUNC_COLORS = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [7:0] BYTE_ESC = 8'd27;
  localparam logic [7:0] BYTE_SP  = 8'd32;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_in;
    logic [6:0] col;
    logic [4:0] row;
    logic [2:0] fg_in;
    logic [2:0] bg_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [2:0] cell_fg;
    logic [2:0] cell_bg;
    logic [1:0] cell_attr;
    logic [6:0] cursor_col_out;
    logic [4:0] cursor_row_out;
    logic       escape_busy;
  } out_item_t;

  // Sweep kinds run by the datapath.
  typedef enum logic [1:0] {
    SWEEP_CLEAR,
    SWEEP_SCROLL,
    SWEEP_ERASE
  } sweep_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic   step;      // execute the held item's direct work (no sweep)
    logic   sweep_go;  // start a sweep over screen cells
    sweep_e kind;
    logic   walk;      // advance the sweep by one step
    logic   rd_issue;  // issue the read of the held read request
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic   need_sweep;
    sweep_e kind;
    logic   sweep_done;
  } stat_t;

  function automatic logic [15:0] make_cell(logic [7:0] ch, logic [2:0] fg,
                                            logic [2:0] bg, logic [1:0] at);
    return {at, bg, fg, ch};
  endfunction

endpackage

### rtl/att_if.sv
// Valid/ready channel interface carrying a typed payload.
// Depends on att_pkg for the default payload type.
interface att_if #(
  parameter type T = att_pkg::in_item_t
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/att_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module att_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/att_datapath.sv
// Datapath of the terminal: cursor, colors, escape parser, screen RAM, sweeps.
// Depends on att_pkg and att_ram.
module att_datapath #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int ESC_BUF_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  att_pkg::in_item_t item_i,
  input  att_pkg::ctrl_t    ctrl_i,
  output att_pkg::stat_t    stat_o,
  output att_pkg::out_item_t result_o
);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(ESC_BUF_LEN);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);

  logic [6:0] ccol_q, ccol_d;
  logic [4:0] crow_q, crow_d;
  logic [2:0] fg_q, fg_d, bg_q, bg_d;
  logic [1:0] attr_q, attr_d;
  logic       esc_q, esc_d;
  logic [SW-1:0] stored_q, stored_d;
  logic       bracket_q, bracket_d;
  logic [7:0] first_q, first_d, last_q, last_d;
  logic       zero_q, zero_d;
  logic [1:0] phase_q, phase_d;
  logic       neg_q, neg_d;
  logic [9:0] pval_q, pval_d;

  // Sweep engine and screen RAM access.
  logic           sw_busy_q, sw_busy_d;
  att_pkg::sweep_e sw_kind_q, sw_kind_d;
  logic [AW-1:0]  sw_addr_q, sw_addr_d;   // destination cell
  logic           sw_rd_q, sw_rd_d;       // scroll and erase: read pending from last cycle
  logic [AW-1:0]  sw_end_q, sw_end_d;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;

  logic [15:0]    cell_q, cell_d;
  logic [15:0]    cell_now;
  logic           cell_vld_q, cell_vld_d;
  logic           rd_pend_q, rd_pend_d;   // read data arrives this cycle
  logic           need_q, need_d;
  att_pkg::sweep_e nkind_q, nkind_d;
  logic [AW-1:0]  nend_q, nend_d, nstart_q, nstart_d;

  att_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] cell_idx(logic [4:0] r, logic [6:0] c);
    return AW'(r * COLUMNS + c);
  endfunction

  logic [7:0] ch;
  logic is_letter, is_digit, is_space;
  logic [10:0] nx;
  logic [13:0] pmul;

  always_comb begin
    ccol_d = ccol_q; crow_d = crow_q; fg_d = fg_q; bg_d = bg_q; attr_d = attr_q;
    esc_d = esc_q; stored_d = stored_q; bracket_d = bracket_q; first_d = first_q;
    last_d = last_q; zero_d = zero_q; phase_d = phase_q; neg_d = neg_q; pval_d = pval_q;
    need_d = 1'b0; nkind_d = nkind_q; nend_d = nend_q; nstart_d = nstart_q;
    sw_busy_d = sw_busy_q; sw_kind_d = sw_kind_q; sw_addr_d = sw_addr_q;
    sw_rd_d = 1'b0; sw_end_d = sw_end_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    cell_d = cell_q; cell_vld_d = cell_vld_q;
    rd_pend_d = ctrl_i.rd_issue;
    // The captured cell comes straight from the RAM in the cycle its read data lands (zero for an out-of-range read).
    cell_now = rd_pend_q ? (cell_vld_q ? rdata : 16'd0) : cell_q;
    ch = item_i.char_in;
    is_letter = (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122);
    is_digit  = ch >= 8'd48 && ch <= 8'd57;
    is_space  = ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13);
    nx = (11'(ccol_q) + 11'd8) & ~11'd7;
    pmul = 14'(pval_q) * 14'd10 + 14'(ch - 8'd48);

    if (rd_pend_q) cell_d = cell_now;

    if (ctrl_i.step) begin
      cell_vld_d = 1'b0;
      cell_d = '0;
      case (item_i.func)
        att_pkg::FUNC_CURSOR: begin
          if (32'(item_i.col) < COLUMNS && 32'(item_i.row) < ROWS) begin
            ccol_d = item_i.col; crow_d = item_i.row;
          end
        end
        att_pkg::FUNC_COLORS: begin
          fg_d = item_i.fg_in; bg_d = item_i.bg_in;
        end
        att_pkg::FUNC_READ: ;
        default: begin
          if (ch == 8'd10) begin
            ccol_d = '0;
            if (32'(crow_q) + 1 >= ROWS) begin
              need_d = 1'b1; nkind_d = att_pkg::SWEEP_SCROLL;
            end else crow_d = crow_q + 5'd1;
          end else if (ch == 8'd13) begin
            ccol_d = '0;
          end else if (ch == 8'd9) begin
            if (32'(nx) >= COLUMNS) begin
              ccol_d = '0;
              if (32'(crow_q) + 1 >= ROWS) begin
                need_d = 1'b1; nkind_d = att_pkg::SWEEP_SCROLL;
              end else crow_d = crow_q + 5'd1;
            end else ccol_d = nx[6:0];
          end else if (ch == 8'd8) begin
            if (ccol_q != 0) begin
              ccol_d = ccol_q - 7'd1;
              // Char-only write needs read-modify-write: run as a one-cell erase.
              need_d = 1'b1; nkind_d = att_pkg::SWEEP_ERASE;
              nstart_d = cell_idx(crow_q, ccol_q - 7'd1);
              nend_d = nstart_d;
            end
          end else if (ch == att_pkg::BYTE_ESC) begin
            esc_d = 1'b1; stored_d = '0; bracket_d = 1'b0; first_d = '0; last_d = '0;
            zero_d = 1'b0; phase_d = '0; neg_d = 1'b0; pval_d = '0;
          end else if (esc_q) begin
            if (32'(stored_q) < ESC_BUF_LEN - 2) begin
              stored_d = stored_q + SW'(1);
              if (!zero_q) begin
                if (ch == 8'd0) zero_d = 1'b1;
                else begin
                  if (stored_q == SW'(0)) bracket_d = ch == 8'd91;
                  if (stored_q == SW'(1)) first_d = ch;
                  if (stored_q >= SW'(1)) begin
                    case (phase_q)
                      2'd0: begin
                        if (!is_space) begin
                          if (ch == 8'd43 || ch == 8'd45) begin
                            neg_d = ch == 8'd45; phase_d = 2'd1;
                          end else if (is_digit) begin
                            pval_d = 10'(ch - 8'd48); phase_d = 2'd2;
                          end else phase_d = 2'd3;
                        end
                      end
                      2'd1, 2'd2: begin
                        if (is_digit) begin
                          pval_d = (pmul > 14'd999) ? 10'd999 : pmul[9:0];
                          phase_d = 2'd2;
                        end else phase_d = 2'd3;
                      end
                      default: ;
                    endcase
                  end
                  last_d = ch;
                end
              end
            end
            if (is_letter) begin
              esc_d = 1'b0;
              // The command is the last stored byte after this one's update.
              if (last_d != 8'd0 && bracket_d) begin
                case (last_d)
                  8'd65: if (crow_q != 0) crow_d = crow_q - 5'd1;
                  8'd66: if (32'(crow_q) < ROWS - 1) crow_d = crow_q + 5'd1;
                  8'd67: if (32'(ccol_q) < COLUMNS - 1) ccol_d = ccol_q + 7'd1;
                  8'd68: if (ccol_q != 0) ccol_d = ccol_q - 7'd1;
                  8'd72: begin ccol_d = '0; crow_d = '0; end
                  8'd74: if (first_d == 8'd50) begin
                    need_d = 1'b1; nkind_d = att_pkg::SWEEP_CLEAR;
                    ccol_d = '0; crow_d = '0;
                  end
                  8'd75: begin
                    need_d = 1'b1; nkind_d = att_pkg::SWEEP_ERASE;
                    nstart_d = cell_idx(crow_q, ccol_q);
                    nend_d = cell_idx(crow_q, 7'(COLUMNS - 1));
                  end
                  8'd109: begin
                    if (pval_d == 10'd0) begin
                      fg_d = 3'd7; bg_d = 3'd0; attr_d = 2'd0;
                    end else if (!neg_d) begin
                      if (pval_d >= 10'd30 && pval_d <= 10'd37) fg_d = 3'(pval_d - 10'd30);
                      else if (pval_d >= 10'd40 && pval_d <= 10'd47)
                        bg_d = 3'(pval_d - 10'd40);
                      else if (pval_d == 10'd1) attr_d = attr_q | 2'd1;
                      else if (pval_d == 10'd4) attr_d = attr_q | 2'd2;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end else if (ch >= 8'd32 && ch <= 8'd126) begin
            we = 1'b1; waddr = cell_idx(crow_q, ccol_q);
            wdata = att_pkg::make_cell(ch, fg_q, bg_q, attr_q);
            if (32'(ccol_q) + 1 >= COLUMNS) begin
              ccol_d = '0;
              if (32'(crow_q) + 1 >= ROWS) begin
                need_d = 1'b1; nkind_d = att_pkg::SWEEP_SCROLL;
              end else crow_d = crow_q + 5'd1;
            end else ccol_d = ccol_q + 7'd1;
          end
        end
      endcase
    end

    if (ctrl_i.rd_issue) begin
      raddr = cell_idx(item_i.row, item_i.col);
      cell_vld_d = 32'(item_i.col) < COLUMNS && 32'(item_i.row) < ROWS;
    end

    if (ctrl_i.sweep_go) begin
      sw_busy_d = 1'b1; sw_kind_d = ctrl_i.kind; sw_rd_d = 1'b0;
      case (ctrl_i.kind)
        att_pkg::SWEEP_CLEAR:  begin sw_addr_d = '0; sw_end_d = LAST_CELL; end
        att_pkg::SWEEP_SCROLL: begin sw_addr_d = '0; sw_end_d = LAST_CELL; end
        default:               begin sw_addr_d = nstart_q; sw_end_d = nend_q; end
      endcase
    end else if (ctrl_i.walk && sw_busy_q) begin
      case (sw_kind_q)
        att_pkg::SWEEP_CLEAR: begin
          we = 1'b1; waddr = sw_addr_q;
          wdata = att_pkg::make_cell(att_pkg::BYTE_SP, fg_q, bg_q, 2'd0);
          sw_addr_d = sw_addr_q + AW'(1);
          if (sw_addr_q == sw_end_q) sw_busy_d = 1'b0;
        end
        att_pkg::SWEEP_SCROLL: begin
          if (sw_addr_q >= LAST_ROW_BASE) begin
            we = 1'b1; waddr = sw_addr_q;
            wdata = att_pkg::make_cell(att_pkg::BYTE_SP, fg_q, bg_q, 2'd0);
            sw_addr_d = sw_addr_q + AW'(1);
            if (sw_addr_q == sw_end_q) sw_busy_d = 1'b0;
          end else if (!sw_rd_q) begin
            raddr = sw_addr_q + AW'(COLUMNS); sw_rd_d = 1'b1;
          end else begin
            we = 1'b1; waddr = sw_addr_q; wdata = rdata;
            sw_addr_d = sw_addr_q + AW'(1);
          end
        end
        default: begin
          if (!sw_rd_q) begin
            raddr = sw_addr_q; sw_rd_d = 1'b1;
          end else begin
            we = 1'b1; waddr = sw_addr_q; wdata = {rdata[15:8], att_pkg::BYTE_SP};
            sw_addr_d = sw_addr_q + AW'(1);
            if (sw_addr_q == sw_end_q) sw_busy_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccol_q <= '0; crow_q <= '0; fg_q <= 3'd7; bg_q <= '0; attr_q <= '0;
      esc_q <= 1'b0; stored_q <= '0; bracket_q <= 1'b0; first_q <= '0; last_q <= '0;
      zero_q <= 1'b0; phase_q <= '0; neg_q <= 1'b0; pval_q <= '0;
      sw_busy_q <= 1'b1; sw_kind_q <= att_pkg::SWEEP_CLEAR; sw_addr_q <= '0;
      sw_rd_q <= 1'b0; sw_end_q <= LAST_CELL;
      cell_vld_q <= 1'b0; rd_pend_q <= 1'b0; need_q <= 1'b0;
      nkind_q <= att_pkg::SWEEP_CLEAR;
    end else begin
      ccol_q <= ccol_d; crow_q <= crow_d; fg_q <= fg_d; bg_q <= bg_d; attr_q <= attr_d;
      esc_q <= esc_d; stored_q <= stored_d; bracket_q <= bracket_d; first_q <= first_d;
      last_q <= last_d; zero_q <= zero_d; phase_q <= phase_d; neg_q <= neg_d;
      pval_q <= pval_d;
      sw_busy_q <= sw_busy_d; sw_kind_q <= sw_kind_d; sw_addr_q <= sw_addr_d;
      sw_rd_q <= sw_rd_d; sw_end_q <= sw_end_d;
      cell_vld_q <= cell_vld_d; rd_pend_q <= rd_pend_d; need_q <= need_d;
      nkind_q <= nkind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nend_q <= nend_d; nstart_q <= nstart_d; cell_q <= cell_d;
  end

  assign stat_o.need_sweep = need_q;
  assign stat_o.kind       = nkind_q;
  assign stat_o.sweep_done = !sw_busy_q;

  assign result_o.cell_char      = cell_now[7:0];
  assign result_o.cell_fg        = cell_now[10:8];
  assign result_o.cell_bg        = cell_now[13:11];
  assign result_o.cell_attr      = cell_now[15:14];
  assign result_o.cursor_col_out = ccol_q;
  assign result_o.cursor_row_out = crow_q;
  assign result_o.escape_busy    = esc_q;
endmodule

### rtl/att_ctrl.sv
// Controller of the terminal: sequences accept, execute, sweeps and output.
// Depends on att_pkg.
module att_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     func_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           hold_o,
  output logic           load_o,
  output att_pkg::ctrl_t ctrl_o,
  input  att_pkg::stat_t stat_i
);
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ovld_q, ovld_d;
  logic       out_free;

  always_comb begin
    state_d = state_q; ovld_d = ovld_q;
    ctrl_o = '0; ctrl_o.kind = stat_i.kind;
    in_ready_o = 1'b0; hold_o = 1'b0; load_o = 1'b0;
    out_free = !ovld_q || out_ready_i;
    if (ovld_q && out_ready_i) ovld_d = 1'b0;
    case (state_q)
      S_INIT: begin
        ctrl_o.walk = 1'b1;
        if (stat_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        hold_o = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        ctrl_o.step = 1'b1;
        ctrl_o.rd_issue = func_i == att_pkg::FUNC_READ;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.need_sweep) begin
          ctrl_o.sweep_go = 1'b1; state_d = S_SWEEP;
        end else if (out_free) begin
          load_o = 1'b1; ovld_d = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SWEEP: begin
        ctrl_o.walk = 1'b1;
        if (stat_i.sweep_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load_o = 1'b1; ovld_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; ovld_q <= ovld_d;
    end
  end
endmodule

### rtl/ansi_text_terminal_unit.sv
// Top level of the ANSI text terminal: controller, datapath and screen RAM.
// Depends on att_pkg, att_if, att_ctrl, att_datapath and att_ram.
//
// The block takes command items on in_ch (put character, set cursor, set
// colors, read cell) and gives exactly one result per item on out_ch: the
// read cell (zero unless the item was a read), the cursor and the escape flag.
// A transfer happens on a rising edge with valid and ready both high.
// Simple items pass through an execute state and then a check state after the
// input transfer, and the result is loaded in the check state; the next item
// is taken only back in the idle state, once the last one is through.
// A newline at the bottom row scrolls: the sweep reads each moved cell from the
// row below and then rewrites it, and blanks the last row with one write per
// cell, with input held off meanwhile.
// A 2J clear writes COLUMNS*ROWS cells, one per cycle; erase to end of line
// and backspace read-modify-write the cells concerned, a read and then a write each.
// After reset a clearing pass fills all COLUMNS*ROWS cells with white-on-black
// spaces; in_ch ready stays low until it ends.
// Each result is copied into an output register that holds while the receiver
// stalls; one more item is taken and executed meanwhile, and its result waits
// until the register has been transferred out.
module ansi_text_terminal_unit #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int ESC_BUF_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  att_if.sink   in_ch,
  att_if.source out_ch
);
  att_pkg::in_item_t  item_q;
  att_pkg::ctrl_t     ctrl;
  att_pkg::stat_t     stat;
  att_pkg::out_item_t result;
  att_pkg::out_item_t result_q;
  logic               hold;
  logic               load;
  logic               out_valid;

  always_ff @(posedge clk_i) begin
    if (hold) begin
      item_q <= in_ch.data;
    end
  end

  // Output register: decouples the waiting result from the live terminal state.
  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result;
    end
  end

  att_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .func_i(item_q.func),
    .out_valid_o(out_valid), .out_ready_i(out_ch.ready),
    .hold_o(hold), .load_o(load), .ctrl_o(ctrl), .stat_i(stat)
  );

  att_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS), .ESC_BUF_LEN(ESC_BUF_LEN)) u_dp (
    .clk_i, .rst_ni, .item_i(item_q), .ctrl_i(ctrl), .stat_o(stat), .result_o(result)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data  = result_q;

  a_cursor_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(result.cursor_col_out) < COLUMNS) else $error("cursor column out of range");
  a_cursor_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(result.cursor_row_out) < ROWS) else $error("cursor row out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
endmodule
